>>> rtl/core/uvq_pkg.sv
// Package for the unique value queue engine: action and status codes,
// payload structs and sequencer states. No dependencies.
`timescale 1ns / 1ps

package uvq_pkg;

    typedef enum logic [2:0] {
        ACT_ENQ   = 3'd0,
        ACT_DEQ   = 3'd1,
        ACT_EXIST = 3'd2,
        ACT_CLEAR = 3'd3,
        ACT_DUP   = 3'd4,
        ACT_MUL   = 3'd5,
        ACT_REV   = 3'd6,
        ACT_PEEK  = 3'd7
    } t_action;

    typedef enum logic [2:0] {
        STS_OK      = 3'd0,
        STS_FULL    = 3'd1,
        STS_PRESENT = 3'd2,
        STS_EMPTY   = 3'd3,
        STS_FEW     = 3'd4,
        STS_PROD    = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SRCH,
        ST_POST,
        ST_RDF,
        ST_RDS,
        ST_MULT,
        ST_DONE
    } t_state;

    typedef struct packed {
        t_action            action;
        logic signed [31:0] value;
    } t_in;

    typedef struct packed {
        t_status            status;
        logic signed [31:0] data;
        logic               found;
        logic               is_empty;
        logic [4:0]         count;
    } t_out;

endpackage

>>> rtl/core/unique_value_queue_engine.sv
// Top level of the unique value queue engine: sequencer around one entry RAM.
// Depends on uvq_pkg and uvq_ram.
`timescale 1ns / 1ps

// The engine holds up to DEPTH signed 32-bit values in a circular buffer kept
// in one RAM, addressed through a head pointer and a direction bit, so that
// dequeue, push at the front and reverse only move pointers. Each beat on the
// input carries one action and returns exactly one result beat. Clear,
// reverse, every rejected action, and enqueue or exists on an empty queue
// go straight to the result state; dequeue, peek and duplicate first read
// the front entry. Otherwise enqueue, exists and mul scan the held entries
// through the single RAM read port, one entry per cycle; mul reads the two
// front entries ahead of the scan, so the longest action is a mul on a
// queue one short of full. A result that finds the output register still
// occupied waits there until the receiver takes the previous beat. One
// action is in flight at a time; a new beat is taken while the previous
// result still waits on the output.
module unique_value_queue_engine #(
    parameter int DEPTH = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  uvq_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output uvq_pkg::t_out o_out_data
);
    import uvq_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW:0]   DEPTH_W = (PW + 1)'(DEPTH);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

    t_state          r_state, n_state;
    logic [PW-1:0]   r_head, n_head;
    logic            r_dir, n_dir;
    logic [CW-1:0]   r_count, n_count;
    t_action         r_act, n_act;
    logic [31:0]     r_val, n_val;
    logic [31:0]     r_a, n_a;
    logic [CW-1:0]   r_idx, n_idx;
    logic            r_cmp, n_cmp;
    logic            r_hit, n_hit;
    t_status         r_status, n_status;
    logic [31:0]     r_data, n_data;
    logic            r_found, n_found;
    logic            r_out_valid, n_out_valid;
    t_out            r_out, n_out;

    logic            ram_we;
    logic [PW-1:0]   ram_waddr;
    logic [31:0]     ram_wdata;
    logic [PW-1:0]   ram_raddr;
    logic [31:0]     ram_rdata;
    logic [31:0]     prod;

    // Physical slot of the entry at offset off from base, walking in the
    // given direction around the ring.
    function automatic logic [PW-1:0] phys(input logic [PW-1:0] base,
                                           input logic dir,
                                           input logic [PW-1:0] off);
        logic [PW:0] s;
        if (!dir) begin
            s = {1'b0, base} + {1'b0, off};
            if (s >= DEPTH_W) begin
                s = s - DEPTH_W;
            end
        end else begin
            if (off > base) begin
                s = {1'b0, base} + DEPTH_W - {1'b0, off};
            end else begin
                s = {1'b0, base} - {1'b0, off};
            end
        end
        return s[PW-1:0];
    endfunction

    uvq_ram #(
        .WIDTH (32),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Only the low 32 bits of the product are kept.
    assign prod = r_a * ram_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_head      <= '0;
            r_dir       <= 1'b0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_dir       <= n_dir;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        r_act    <= n_act;
        r_val    <= n_val;
        r_a      <= n_a;
        r_idx    <= n_idx;
        r_cmp    <= n_cmp;
        r_hit    <= n_hit;
        r_status <= n_status;
        r_data   <= n_data;
        r_found  <= n_found;
        r_out    <= n_out;
    end

    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_dir       = r_dir;
        n_count     = r_count;
        n_act       = r_act;
        n_val       = r_val;
        n_a         = r_a;
        n_idx       = r_idx;
        n_cmp       = r_cmp;
        n_hit       = r_hit;
        n_status    = r_status;
        n_data      = r_data;
        n_found     = r_found;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;
        ram_we      = 1'b0;
        ram_waddr   = r_head;
        ram_wdata   = r_val;
        ram_raddr   = r_head;

        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_act    = i_in_data.action;
                    n_val    = i_in_data.value;
                    n_status = STS_OK;
                    n_data   = '0;
                    n_found  = 1'b0;
                    n_idx    = '0;
                    n_cmp    = 1'b0;
                    n_hit    = 1'b0;
                    n_state  = ST_DONE;
                    case (i_in_data.action)
                        ACT_ENQ: begin
                            if (r_count == DEPTH_C) begin
                                n_status = STS_FULL;
                            end else if (r_count == '0) begin
                                ram_we    = 1'b1;
                                ram_waddr = r_head;
                                ram_wdata = i_in_data.value;
                                n_count   = CW'(1);
                            end else begin
                                n_state = ST_SRCH;
                            end
                        end
                        ACT_DEQ, ACT_PEEK: begin
                            if (r_count == '0) begin
                                n_status = STS_EMPTY;
                            end else begin
                                n_state = ST_RDF;
                            end
                        end
                        ACT_EXIST: begin
                            if (r_count != '0) begin
                                n_state = ST_SRCH;
                            end
                        end
                        ACT_CLEAR: begin
                            n_count = '0;
                        end
                        ACT_DUP: begin
                            if (r_count == '0) begin
                                n_status = STS_EMPTY;
                            end else if (r_count == DEPTH_C) begin
                                n_status = STS_FULL;
                            end else begin
                                n_state = ST_RDF;
                            end
                        end
                        ACT_MUL: begin
                            if (r_count < CW'(2)) begin
                                n_status = STS_FEW;
                            end else if (r_count == DEPTH_C) begin
                                n_status = STS_FULL;
                            end else begin
                                n_state = ST_RDS;
                            end
                        end
                        ACT_REV: begin
                            if (r_count != '0) begin
                                n_head = phys(r_head, r_dir, PW'(r_count - 1'b1));
                            end
                            n_dir = ~r_dir;
                        end
                        default: begin
                            n_state = ST_DONE;
                        end
                    endcase
                end
            end

            ST_SRCH: begin
                if (r_cmp && ram_rdata == r_val) begin
                    n_hit = 1'b1;
                end
                if (r_idx != r_count) begin
                    ram_raddr = phys(r_head, r_dir, r_idx[PW-1:0]);
                    n_idx     = r_idx + 1'b1;
                    n_cmp     = 1'b1;
                end else begin
                    n_cmp   = 1'b0;
                    n_state = ST_POST;
                end
            end

            ST_POST: begin
                n_state = ST_DONE;
                case (r_act)
                    ACT_ENQ: begin
                        if (r_hit) begin
                            n_status = STS_PRESENT;
                        end else begin
                            ram_we    = 1'b1;
                            ram_waddr = phys(r_head, r_dir, PW'(r_count));
                            ram_wdata = r_val;
                            n_count   = r_count + 1'b1;
                        end
                    end
                    ACT_EXIST: begin
                        n_found = r_hit;
                    end
                    ACT_MUL: begin
                        if (r_hit) begin
                            n_status = STS_PROD;
                        end else begin
                            n_head    = phys(r_head, ~r_dir, PW'(1));
                            ram_we    = 1'b1;
                            ram_waddr = n_head;
                            ram_wdata = r_val;
                            n_count   = r_count + 1'b1;
                        end
                    end
                    default: begin
                        n_state = ST_DONE;
                    end
                endcase
            end

            ST_RDF: begin
                n_state = ST_DONE;
                case (r_act)
                    ACT_DEQ: begin
                        n_data  = ram_rdata;
                        n_head  = phys(r_head, r_dir, PW'(1));
                        n_count = r_count - 1'b1;
                    end
                    ACT_DUP: begin
                        n_head    = phys(r_head, ~r_dir, PW'(1));
                        ram_we    = 1'b1;
                        ram_waddr = n_head;
                        ram_wdata = ram_rdata;
                        n_count   = r_count + 1'b1;
                    end
                    default: begin
                        n_data = ram_rdata;
                    end
                endcase
            end

            ST_RDS: begin
                n_a       = ram_rdata;
                ram_raddr = phys(r_head, r_dir, PW'(1));
                n_state   = ST_MULT;
            end

            ST_MULT: begin
                n_val   = prod;
                n_idx   = '0;
                n_cmp   = 1'b0;
                n_hit   = 1'b0;
                n_state = ST_SRCH;
            end

            ST_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid    = 1'b1;
                    n_out.status   = r_status;
                    n_out.data     = r_data;
                    n_out.found    = r_found;
                    n_out.is_empty = (r_count == '0);
                    n_out.count    = 5'(r_count);
                    n_state        = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH_C)
        else $error("fill count exceeds depth");

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_in_data.action == ACT_CLEAR) |=> (r_count == '0))
        else $error("clear did not empty the queue");

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SRCH) |-> (r_idx <= r_count))
        else $error("scan index ran past the held entries");

    a_err_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.status != STS_OK) |-> (o_out_data.data == '0))
        else $error("rejected action returned data");
`endif

endmodule

>>> rtl/core/uvq_ram.sv
// Generic simple dual-port RAM with one write port and a registered read.
// Depends on nothing.
`timescale 1ns / 1ps

module uvq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
